// ===== hdl/bqi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bqi_pkg;

	localparam int SampleW = 16;
	localparam int CfgIdxW = 3;

	typedef logic signed [SampleW-1:0] sample_t;

	typedef struct packed {
		sample_t b0;
		sample_t b1;
		sample_t b2;
		sample_t a1;
		sample_t a2;
		sample_t init_in;
		sample_t init_out;
	} coef_t;

	typedef struct packed {
		sample_t x1;
		sample_t x2;
		sample_t y1;
		sample_t y2;
	} hist_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_B0       = 3'd0,
		CFG_B1       = 3'd1,
		CFG_B2       = 3'd2,
		CFG_A1       = 3'd3,
		CFG_A2       = 3'd4,
		CFG_INIT_IN  = 3'd5,
		CFG_INIT_OUT = 3'd6
	} cfg_idx_t;

	localparam sample_t RstB0      = 16'sh76B0;
	localparam sample_t RstB1      = 16'sh76B0;
	localparam sample_t RstB2      = 16'sh76B0;
	localparam sample_t RstA1      = 16'sh74A7;
	localparam sample_t RstA2      = 16'sh94D7;
	localparam sample_t RstInitIn  = 16'sh8001;
	localparam sample_t RstInitOut = 16'shC000;

	localparam int unsigned ShiftB0 = 24;
	localparam int unsigned ShiftB1 = 23;
	localparam int unsigned ShiftB2 = 24;
	localparam int unsigned ShiftA1 = 14;
	localparam int unsigned ShiftA2 = 15;

	// rounded product, arithmetic shift, low 16 bits
	function automatic sample_t bq_term(sample_t c, sample_t v, int unsigned k);
		logic signed [31:0] p;
		logic signed [31:0] s;
		p = 32'(c) * 32'(v);
		p = p + (32'sd1 <<< (k - 1));
		s = p >>> k;
		return s[SampleW-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/bqi_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bqi_cfg import bqi_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire logic [CfgIdxW-1:0] wr_index,
	input  wire sample_t            wr_data,
	output coef_t                   coef
);

	coef_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0       <= RstB0;
			coef_q.b1       <= RstB1;
			coef_q.b2       <= RstB2;
			coef_q.a1       <= RstA1;
			coef_q.a2       <= RstA2;
			coef_q.init_in  <= RstInitIn;
			coef_q.init_out <= RstInitOut;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_B0:       coef_q.b0       <= wr_data;
				CFG_B1:       coef_q.b1       <= wr_data;
				CFG_B2:       coef_q.b2       <= wr_data;
				CFG_A1:       coef_q.a1       <= wr_data;
				CFG_A2:       coef_q.a2       <= wr_data;
				CFG_INIT_IN:  coef_q.init_in  <= wr_data;
				CFG_INIT_OUT: coef_q.init_out <= wr_data;
				default:      ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

`default_nettype wire

// ===== hdl/bqi_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bqi_datapath import bqi_pkg::*; (
	input  wire coef_t       coef,
	input  wire hist_t       hist,
	input  wire sample_t     x,
	input  wire logic        restart,
	output sample_t          y,
	output hist_t            hist_next
);

	hist_t   h;
	sample_t t_b0, t_b1, t_b2, t_a1, t_a2;

	// restart reloads history before this sample
	always_comb begin
		h = hist;
		if (restart) begin
			h.x1 = coef.init_in;
			h.x2 = coef.init_in;
			h.y1 = coef.init_out;
			h.y2 = coef.init_out;
		end
	end

	assign t_b0 = bq_term(coef.b0, x,    ShiftB0);
	assign t_b1 = bq_term(coef.b1, h.x1, ShiftB1);
	assign t_b2 = bq_term(coef.b2, h.x2, ShiftB2);
	assign t_a1 = bq_term(coef.a1, h.y1, ShiftA1);
	assign t_a2 = bq_term(coef.a2, h.y2, ShiftA2);

	// wraps to 16 bits
	assign y = t_b0 + t_b1 + t_b2 + t_a1 + t_a2;

	always_comb begin
		hist_next.x1 = x;
		hist_next.x2 = h.x1;
		hist_next.y1 = y;
		hist_next.y2 = h.y1;
	end

endmodule

`default_nettype wire

// ===== hdl/fixed_point_biquad_iir.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall   | sample_in, restart
// out     | output    | out_valid / out_stall | sample_out
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per cycle sustained while out_stall stays low; sample_out follows acceptance through
// the input register, one pass of five multiplies and a sum, and the output register
// history and coefficients reset to their default values; cfg_ready is always high
// out_stall holds the output register; in_stall rises only when the input register is also full
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_biquad_iir import bqi_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire sample_t            sample_in,
	input  wire logic               restart,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output sample_t                 sample_out,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire sample_t            cfg_data
);

	coef_t   coef;
	hist_t   hist_q;
	hist_t   hist_next;
	sample_t y;

	logic    valid_s1;
	sample_t sample_s1;
	logic    restart_s1;
	logic    out_valid_q;
	sample_t sample_out_q;

	logic    advance;
	logic    fire;
	logic    take_in;

	assign cfg_ready = 1'b1;

	bqi_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.coef     (coef)
	);

	bqi_datapath u_dp (
		.coef      (coef),
		.hist      (hist_q),
		.x         (sample_s1),
		.restart   (restart_s1),
		.y         (y),
		.hist_next (hist_next)
	);

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			sample_s1  <= sample_in;
			restart_s1 <= restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sample_out_q <= y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q.x1 <= RstInitIn;
			hist_q.x2 <= RstInitIn;
			hist_q.y1 <= RstInitOut;
			hist_q.y2 <= RstInitOut;
		end else if (fire) begin
			hist_q <= hist_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled without a held item");

	a_fire_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("result lost after a pass");

	a_feedback_matches: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> hist_q.y1 == sample_out_q)
		else $error("fed back output differs from result");

	a_restart_reload: assert property (@(posedge clk) disable iff (!arst_n)
		fire && restart_s1 |=> hist_q.x2 == $past(coef.init_in)
			&& hist_q.y2 == $past(coef.init_out))
		else $error("restart did not reload history");

endmodule

`default_nettype wire

// ===== bench/fixed_point_biquad_iir_chk.sv =====
`timescale 1ns / 1ps

module fixed_point_biquad_iir_chk import bqi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  sample_t            sample_in,
	input  logic               restart,
	input  logic               out_valid,
	input  logic               out_stall,
	input  sample_t            sample_out,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  sample_t            cfg_data,
	output int                 n_fail,
	output int                 n_pending
);

	coef_t   coef_copy;
	hist_t   hist;
	sample_t filtered_q [$];
	sample_t want;
	sample_t y_next;
	longint  acc;
	int      fail_count = 0;
	int      pending_count = 0;

	assign n_fail = fail_count;
	assign n_pending = pending_count;

	function automatic longint rounded_term(sample_t c, sample_t v, int unsigned k);
		longint p;
		p = longint'(c) * longint'(v) + (64'sd1 <<< (k - 1));
		return p >>> k;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_copy = '{b0: RstB0, b1: RstB1, b2: RstB2, a1: RstA1, a2: RstA2,
				init_in: RstInitIn, init_out: RstInitOut};
			hist = '{x1: RstInitIn, x2: RstInitIn, y1: RstInitOut, y2: RstInitOut};
			filtered_q.delete();
			pending_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (filtered_q.size() == 0) begin
					report_mismatch($sformatf("sample_out %0d with no item pending",
						sample_out));
				end else begin
					want = filtered_q.pop_front();
					if (sample_out !== want)
						report_mismatch($sformatf("sample_out got %0d want %0d",
							sample_out, want));
				end
			end
			if (in_valid && !in_stall) begin
				if (restart)
					hist = '{x1: coef_copy.init_in, x2: coef_copy.init_in,
						y1: coef_copy.init_out, y2: coef_copy.init_out};
				acc = rounded_term(coef_copy.b0, sample_in, ShiftB0)
					+ rounded_term(coef_copy.b1, hist.x1, ShiftB1)
					+ rounded_term(coef_copy.b2, hist.x2, ShiftB2)
					+ rounded_term(coef_copy.a1, hist.y1, ShiftA1)
					+ rounded_term(coef_copy.a2, hist.y2, ShiftA2);
				y_next = acc[SampleW-1:0];
				hist.x2 = hist.x1;
				hist.x1 = sample_in;
				hist.y2 = hist.y1;
				hist.y1 = y_next;
				filtered_q.push_back(y_next);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_B0:       coef_copy.b0 = cfg_data;
					CFG_B1:       coef_copy.b1 = cfg_data;
					CFG_B2:       coef_copy.b2 = cfg_data;
					CFG_A1:       coef_copy.a1 = cfg_data;
					CFG_A2:       coef_copy.a2 = cfg_data;
					CFG_INIT_IN:  coef_copy.init_in = cfg_data;
					CFG_INIT_OUT: coef_copy.init_out = cfg_data;
					default: ;
				endcase
			end
			pending_count <= filtered_q.size();
		end
	end

endmodule

// ===== bench/fixed_point_biquad_iir_tb.sv =====
`timescale 1ns / 1ps

module fixed_point_biquad_iir_tb;
	import bqi_pkg::*;

	localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;
	localparam sample_t SMax = 16'sh7FFF;
	localparam sample_t SMin = 16'sh8000;
	localparam int CycleLimit = 400000;
	localparam int HoldCycles = 80;
	localparam int RandPhases = 8;
	localparam int ItemsPerPhase = 85;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	sample_t            sample_in;
	logic               restart;
	logic               out_valid;
	logic               out_stall;
	sample_t            sample_out;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	sample_t            cfg_data;
	int                 n_fail;
	int                 n_pending;

	bit idle_on = 1'b1;
	bit hold_req = 1'b0;

	fixed_point_biquad_iir u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	fixed_point_biquad_iir_chk u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.n_fail     (n_fail),
		.n_pending  (n_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// receiver side: random stall bursts, plus one long hold on request
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				for (int n = 0; n < HoldCycles; n++)
					@(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	function automatic sample_t rand_sample();
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(3))
					0: return SMax;
					1: return SMin;
					2: return '0;
					default: return '1;
				endcase
			end
			1, 2: return sample_t'($urandom_range(511)) - 16'sd256;
			default: return sample_t'($urandom());
		endcase
	endfunction

	task automatic send_sample(sample_t x, logic r);
		if (idle_on && !hold_req && $urandom_range(3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= x;
		restart <= r;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (n_pending != 0);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, sample_t d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_coefs(coef_t c);
		write_reg(CFG_B0, c.b0);
		write_reg(CFG_B1, c.b1);
		write_reg(CFG_B2, c.b2);
		write_reg(CfgIdxUnused, sample_t'($urandom()));
		write_reg(CFG_A1, c.a1);
		write_reg(CFG_A2, c.a2);
		write_reg(CFG_INIT_IN, c.init_in);
		write_reg(CFG_INIT_OUT, c.init_out);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		coef_t c;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_in = '0;
		restart = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults from reset, large inputs with and without restart
		send_sample(SMax, 1'b0);
		send_sample(SMax, 1'b0);
		send_sample(SMax, 1'b0);
		send_sample(SMin, 1'b0);
		send_sample(SMin, 1'b0);
		send_sample('0, 1'b0);
		send_sample('1, 1'b0);
		send_sample(16'sd1, 1'b0);
		send_sample(SMax, 1'b1);
		send_sample(SMin, 1'b1);
		send_sample('0, 1'b1);
		send_sample('0, 1'b0);
		wait_drained();

		load_coefs('{b0: SMax, b1: SMax, b2: SMax, a1: SMax, a2: SMax,
			init_in: SMax, init_out: SMax});
		send_sample(SMax, 1'b1);
		send_sample(SMax, 1'b0);
		send_sample(SMax, 1'b0);
		send_sample(SMin, 1'b0);
		send_sample(SMin, 1'b1);
		wait_drained();

		load_coefs('{b0: SMin, b1: SMin, b2: SMin, a1: SMin, a2: SMin,
			init_in: SMin, init_out: SMin});
		send_sample(SMin, 1'b1);
		send_sample(SMin, 1'b0);
		send_sample(SMax, 1'b0);
		send_sample('0, 1'b0);
		send_sample(SMax, 1'b1);
		wait_drained();

		for (int ph = 0; ph < RandPhases; ph++) begin
			idle_on = (ph != 3 && ph != RandPhases - 1);
			c = coef_t'({$urandom(), $urandom(), $urandom(), $urandom()});
			if (ph == 0) begin
				c.b0 = '0;
				c.b1 = '0;
				c.b2 = '0;
				c.a1 = '0;
				c.a2 = '0;
			end
			if (ph == 5)
				c = '{b0: RstB0, b1: RstB1, b2: RstB2, a1: RstA1, a2: RstA2,
					init_in: sample_t'($urandom()), init_out: sample_t'($urandom())};
			load_coefs(c);
			if (ph == 2)
				hold_req = 1'b1;
			for (int i = 0; i < ItemsPerPhase; i++) begin
				if (ph == 4 && i == ItemsPerPhase / 2)
					wait_drained();
				send_sample(rand_sample(), ($urandom_range(15) == 0) || (i == 0));
			end
			wait_drained();
		end

		repeat (4) @(posedge clk);
		if (n_fail == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
